@@ rtl/core/kesd_pkg.sv @@
// Shared definitions for the key escape string decoder.
// Holds the record type, the queue handoff type, decoder mode codes and character codes.
// No dependencies.
package kesd_pkg;

  localparam int LIMIT_DEFAULT = 500;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BSLASH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CARET  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OCTAL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MDASH  = 3'd4;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_META   = 8'h4d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_E      = 8'h65;

  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_HT  = 8'h09;
  localparam logic [7:0] BYTE_VT  = 8'h0b;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_DEL = 8'h7f;
  localparam logic [7:0] CTRL_MASK = 8'h9f;
  localparam logic [7:0] META_BIT  = 8'h80;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_last;
    logic [8:0] length;
  } rec_t;

  // Up to two records handed from the front to the queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    rec_t       a;
    rec_t       b;
  } push_t;

endpackage

@@ rtl/core/kesd_front.sv @@
// Front end of the key escape string decoder: accepts characters and decodes escapes.
// Produces zero, one or two records per item for the record queue.
// Depends on kesd_pkg.
module kesd_front #(
  parameter int LIMIT = kesd_pkg::LIMIT_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_char_i,
  input  logic            is_end_i,
  output kesd_pkg::push_t push_o
);

  // The count reaches LIMIT + 1 at most; keep at least the 9 bits of the length field.
  localparam int CNT_RAW = $clog2(LIMIT + 2);
  localparam int CNT_W = (CNT_RAW > 9) ? CNT_RAW : 9;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic [kesd_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [7:0]                  oct_q, oct_d;
  logic                        meta_q, meta_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        stop_q, stop_d;

  logic             want0, want1, e0, e1, stop0;
  logic [7:0]       v0, v1;
  logic [CNT_W-1:0] cnt0, cnt1;
  logic             is_dig;
  logic [7:0]       letter;
  logic             is_letter;

  always_comb begin
    is_letter = 1'b1;
    letter    = 8'h00;
    unique case (in_char_i)
      kesd_pkg::CH_A: letter = kesd_pkg::BYTE_BEL;
      kesd_pkg::CH_N: letter = kesd_pkg::BYTE_LF;
      kesd_pkg::CH_B: letter = kesd_pkg::BYTE_BS;
      kesd_pkg::CH_T: letter = kesd_pkg::BYTE_HT;
      kesd_pkg::CH_V: letter = kesd_pkg::BYTE_VT;
      kesd_pkg::CH_F: letter = kesd_pkg::BYTE_FF;
      kesd_pkg::CH_R: letter = kesd_pkg::BYTE_CR;
      kesd_pkg::CH_E: letter = kesd_pkg::BYTE_ESC;
      default:        is_letter = 1'b0;
    endcase
  end

  assign is_dig = (in_char_i >= kesd_pkg::CH_ZERO) && (in_char_i <= kesd_pkg::CH_NINE);

  always_comb begin
    mode_d = mode_q;
    oct_d  = oct_q;
    meta_d = meta_q;
    want0  = 1'b0;
    want1  = 1'b0;
    v0     = 8'h00;
    v1     = 8'h00;

    if (is_end_i) begin
      if (!stop_q) begin
        unique case (mode_q)
          kesd_pkg::MODE_OCTAL: begin
            want0 = 1'b1;
            v0    = oct_q;
          end
          kesd_pkg::MODE_BSLASH: begin
            want0 = 1'b1;
            v0    = kesd_pkg::CH_BSLASH;
          end
          kesd_pkg::MODE_CARET: begin
            want0 = 1'b1;
            v0    = 8'h00;
          end
          default: ;
        endcase
      end
    end else if (!stop_q) begin
      unique case (mode_q)
        kesd_pkg::MODE_BSLASH: begin
          mode_d = kesd_pkg::MODE_NORMAL;
          priority if (is_letter) begin
            want0 = 1'b1;
            v0    = letter;
          end else if (in_char_i == kesd_pkg::CH_META) begin
            meta_d = 1'b1;
            mode_d = kesd_pkg::MODE_MDASH;
          end else if (is_dig) begin
            oct_d  = {4'h0, in_char_i[3:0]};
            mode_d = kesd_pkg::MODE_OCTAL;
          end else begin
            want0 = 1'b1;
            v0    = in_char_i;
          end
        end
        kesd_pkg::MODE_CARET: begin
          mode_d = kesd_pkg::MODE_NORMAL;
          want0  = 1'b1;
          v0     = (in_char_i == kesd_pkg::CH_QMARK) ? kesd_pkg::BYTE_DEL
                                                     : (in_char_i & kesd_pkg::CTRL_MASK);
        end
        kesd_pkg::MODE_OCTAL: begin
          if (is_dig) begin
            oct_d = {oct_q[4:0], 3'b000} + {4'h0, in_char_i[3:0]};
          end else begin
            // The run closes; the closing character is then decoded as in normal mode.
            mode_d = kesd_pkg::MODE_NORMAL;
            want0  = 1'b1;
            v0     = oct_q;
            priority if (in_char_i == kesd_pkg::CH_BSLASH) begin
              mode_d = kesd_pkg::MODE_BSLASH;
            end else if (in_char_i == kesd_pkg::CH_CARET) begin
              mode_d = kesd_pkg::MODE_CARET;
            end else begin
              want1 = 1'b1;
              v1    = in_char_i;
            end
          end
        end
        default: begin
          // Normal mode, and the meta dash mode, which swallows one dash.
          mode_d = kesd_pkg::MODE_NORMAL;
          if (!(mode_q == kesd_pkg::MODE_MDASH && in_char_i == kesd_pkg::CH_DASH)) begin
            priority if (in_char_i == kesd_pkg::CH_BSLASH) begin
              mode_d = kesd_pkg::MODE_BSLASH;
            end else if (in_char_i == kesd_pkg::CH_CARET) begin
              mode_d = kesd_pkg::MODE_CARET;
            end else begin
              want0 = 1'b1;
              v0    = in_char_i;
            end
          end
        end
      endcase
    end

    e0    = want0;
    cnt0  = cnt_q + CNT_W'(e0);
    stop0 = stop_q || (cnt0 > LIMIT_C);
    e1    = want1 && !stop0;
    cnt1  = cnt0 + CNT_W'(e1);
    if (e0) begin
      meta_d = 1'b0;
    end
    cnt_d  = cnt1;
    stop_d = stop0 || (cnt1 > LIMIT_C);

    push_o.a.out_byte   = meta_q ? (v0 | kesd_pkg::META_BIT) : v0;
    push_o.a.byte_valid = 1'b1;
    push_o.a.is_last    = 1'b0;
    push_o.a.length     = cnt0[8:0];
    push_o.b.out_byte   = v1;
    push_o.b.byte_valid = 1'b1;
    push_o.b.is_last    = 1'b0;
    push_o.b.length     = cnt1[8:0];
    push_o.n            = {1'b0, e0} + {1'b0, e1};

    if (is_end_i) begin
      if (e0) begin
        push_o.b.out_byte   = 8'h00;
        push_o.b.byte_valid = 1'b0;
        push_o.b.is_last    = 1'b1;
        push_o.b.length     = cnt0[8:0];
        push_o.n            = 2'd2;
      end else begin
        push_o.a.out_byte   = 8'h00;
        push_o.a.byte_valid = 1'b0;
        push_o.a.is_last    = 1'b1;
        push_o.a.length     = cnt_q[8:0];
        push_o.n            = 2'd1;
      end
      mode_d = kesd_pkg::MODE_NORMAL;
      oct_d  = 8'h00;
      meta_d = 1'b0;
      cnt_d  = '0;
      stop_d = 1'b0;
    end

    if (!accept_i) begin
      push_o.n = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kesd_pkg::MODE_NORMAL;
      oct_q  <= 8'h00;
      meta_q <= 1'b0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      oct_q  <= oct_d;
      meta_q <= meta_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

@@ rtl/core/kesd_queue.sv @@
// Record queue between the decoder front end and the output stage.
// Takes up to two records per cycle and releases one; flags when two slots are not free.
// Depends on kesd_pkg.
module kesd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kesd_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            empty_o,
  output logic            no_room_o,
  output kesd_pkg::rec_t  head_o
);

  kesd_pkg::rec_t mem_q [kesd_pkg::QDEPTH];

  logic [kesd_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [kesd_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign wr_next   = wr_q + kesd_pkg::QPTR_W'(1);
  assign empty_o   = (cnt_q == '0);
  assign no_room_o = (cnt_q > kesd_pkg::QCNT_W'(kesd_pkg::QDEPTH - 2));
  assign head_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + kesd_pkg::QPTR_W'(push_i.n);
    rd_d  = rd_q + kesd_pkg::QPTR_W'(pop_i);
    cnt_d = cnt_q + kesd_pkg::QCNT_W'(push_i.n) - kesd_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.b;
    end
  end

endmodule

@@ rtl/core/kesd_back.sv @@
// Output stage of the key escape string decoder.
// Holds one record in the output register and refills it from the queue.
// Depends on kesd_pkg.
module kesd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  kesd_pkg::rec_t head_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output kesd_pkg::rec_t rec_o
);

  logic           valid_q, valid_d;
  logic           load;
  kesd_pkg::rec_t rec_q;

  // The register takes a new item when it is empty or its item leaves this cycle.
  assign load    = !valid_q || !out_stall_i;
  assign pop_o   = load && !empty_i;
  assign valid_d = load ? !empty_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

@@ rtl/core/key_escape_string_decoder.sv @@
// Key escape string decoder: takes one character per item and emits decoded raw bytes,
// with a closing record that carries the total length. An input item is taken every
// cycle as long as the four-record queue has two free slots; the output register
// delivers one record per cycle unless out_stall_i is high, so items that yield two
// records (a digit run closed by a plain character, or an end item that flushes a
// pending escape) leave one record at a time and the front stalls once the queue
// backs up. An item's first record passes a queue slot, then the output register.
module key_escape_string_decoder #(
  parameter int LIMIT = kesd_pkg::LIMIT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       is_last_o,
  output logic [8:0] length_o
);

  kesd_pkg::push_t push;
  kesd_pkg::rec_t  head, rec;
  logic            accept, empty, no_room, pop;

  assign in_stall_o = no_room;
  assign accept     = in_valid_i && !no_room;

  kesd_front #(
    .LIMIT(LIMIT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_char_i(in_char_i),
    .is_end_i (is_end_i),
    .push_o   (push)
  );

  kesd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .empty_o  (empty),
    .no_room_o(no_room),
    .head_o   (head)
  );

  kesd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .rec_o      (rec)
  );

  assign out_byte_o   = rec.out_byte;
  assign byte_valid_o = rec.byte_valid;
  assign is_last_o    = rec.is_last;
  assign length_o     = rec.length;

endmodule
